// ===== src/byte_stuffed_frame_deframer_macros.svh =====
// Assertion macros for the byte-stuffed frame deframer.
// Expects clk and rst_n in the scope of use; no other dependencies.
`ifndef BYTE_STUFFED_FRAME_DEFRAMER_MACROS_SVH
`define BYTE_STUFFED_FRAME_DEFRAMER_MACROS_SVH

// Same-cycle implication.
`define BSFD_ASSERT_IMPL(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication.
`define BSFD_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

// ===== src/bsfd_pkg.sv =====
// Shared types and constants for the byte-stuffed frame deframer.
// No dependencies.
package bsfd_pkg;

  // default frame buffer depth in bytes
  localparam int FRAME_BYTES_DEF = 64;

  // configuration port
  localparam int CFG_AW = 4;
  localparam int CFG_DW = 32;

  typedef enum logic [1:0] {
    REG_FLAG   = 2'd0,
    REG_ESCAPE = 2'd1,
    REG_MASK   = 2'd2,
    REG_NONE   = 2'd3
  } bsfd_reg_t;

  localparam logic [7:0] FLAG_RST   = 8'd126;
  localparam logic [7:0] ESCAPE_RST = 8'd125;
  localparam logic [7:0] MASK_RST   = 8'd32;

  localparam logic [15:0] DROP_MAX = 16'hFFFF;

  typedef enum logic {
    S_IDLE,
    S_DRAIN
  } bsfd_state_t;

endpackage

// ===== src/bsfd_store.sv =====
// Frame byte store: one write port, one read port with registered data.
// Depends on nothing but its parameter.
module bsfd_store #(
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/byte_stuffed_frame_deframer.sv =====
// Byte-stuffed frame deframer, top level.
// Depends on bsfd_pkg, bsfd_store and byte_stuffed_frame_deframer_macros.svh.
//
//   channel | ports                                   | role
//   --------+-----------------------------------------+-------------------------------
//   in      | in_valid, in_stall, in_line_byte        | raw line bytes, one per beat
//   out     | out_valid, out_stall, out_frame_byte,   | unstuffed frame bytes, last
//           | out_last_of_frame, out_overflow_count   | marker, drop count
//   cfg     | psel, penable, pwrite, paddr, pwdata,   | flag, escape, mask registers
//           | prdata, pready                          | at 0x0, 0x4, 0x8
//
// A line byte that is neither flag nor escape is written into the frame store at
// the fill level, unless the store is full. A flag on a non-empty buffer drains
// the store via its registered read data into the output register, one read in
// flight at a time; input is stalled during the drain. Out stalls stretch it.
// Reset (synchronous, active low) empties the buffer, clears the escape mark and
// the drop counter and restores register defaults; the store itself is not cleared.
module byte_stuffed_frame_deframer
  import bsfd_pkg::*;
#(
  parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  // line side
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        in_line_byte,
  // frame side
  output logic              out_valid,
  input  logic              out_stall,
  output logic [7:0]        out_frame_byte,
  output logic              out_last_of_frame,
  output logic [15:0]       out_overflow_count,
  // configuration
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

  `include "byte_stuffed_frame_deframer_macros.svh"

  localparam int AW = $clog2(FRAME_BYTES);
  localparam int FW = $clog2(FRAME_BYTES + 1);
  localparam logic [FW-1:0] FILL_MAX = FW'(FRAME_BYTES);

  // ---------------------------------------------------------------- config
  logic [7:0] flag_r, escape_r, mask_r;
  bsfd_reg_t  reg_sel;
  logic       cfg_wr;

  assign pready  = 1'b1;
  assign reg_sel = bsfd_reg_t'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flag_r   <= FLAG_RST;
      escape_r <= ESCAPE_RST;
      mask_r   <= MASK_RST;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_FLAG:   flag_r   <= pwdata[7:0];
        REG_ESCAPE: escape_r <= pwdata[7:0];
        REG_MASK:   mask_r   <= pwdata[7:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_FLAG:   prdata = {24'd0, flag_r};
      REG_ESCAPE: prdata = {24'd0, escape_r};
      REG_MASK:   prdata = {24'd0, mask_r};
      default:    prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- control
  bsfd_state_t   state_r, state_nxt;
  logic [FW-1:0] fill_r, fill_nxt;       // bytes held in the store
  logic [FW-1:0] rd_idx_r, rd_idx_nxt;   // next entry to read during a drain
  logic          esc_pend_r, esc_pend_nxt;
  logic [15:0]   dropped_r, dropped_nxt;
  logic          inflight_r, inflight_nxt; // read data lands next cycle

  logic          out_valid_r, out_valid_nxt;
  logic [7:0]    out_byte_r, out_byte_nxt;
  logic          out_last_r, out_last_nxt;
  logic [15:0]   out_cnt_r, out_cnt_nxt;

  logic          in_acc;
  logic          out_free;   // output register empty at the coming edge
  logic          mem_we, mem_re;
  logic [7:0]    mem_wdata, mem_rdata;

  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    rd_idx_nxt    = rd_idx_r;
    esc_pend_nxt  = esc_pend_r;
    dropped_nxt   = dropped_r;
    inflight_nxt  = 1'b0;
    out_valid_nxt = out_valid_r && out_stall;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    out_cnt_nxt   = out_cnt_r;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    mem_wdata     = in_line_byte;
    in_stall      = 1'b1;

    // read data from the previous cycle goes into the output register
    if (inflight_r) begin
      out_valid_nxt = 1'b1;
      out_byte_nxt  = mem_rdata;
      out_last_nxt  = (rd_idx_r == fill_r);
      out_cnt_nxt   = dropped_r;
    end

    unique case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        // never stalled here, so a valid beat is taken
        if (in_valid) begin
          priority if (in_line_byte == escape_r) begin
            esc_pend_nxt = 1'b1;
          end else if (in_line_byte == flag_r) begin
            // the escape mark survives a flag
            if (fill_r != '0) begin
              rd_idx_nxt = '0;
              state_nxt  = S_DRAIN;
            end
          end else begin
            esc_pend_nxt = 1'b0;
            if (esc_pend_r) begin
              mem_wdata = in_line_byte ^ mask_r;
            end
            if (fill_r < FILL_MAX) begin
              mem_we   = 1'b1;
              fill_nxt = fill_r + FW'(1);
            end else begin
              // over length: drop the frame, count it
              fill_nxt = '0;
              if (dropped_r != DROP_MAX) begin
                dropped_nxt = dropped_r + 16'd1;
              end
            end
          end
        end
      end
      S_DRAIN: begin
        if (!inflight_r && out_free && (rd_idx_r != fill_r)) begin
          mem_re       = 1'b1;
          inflight_nxt = 1'b1;
          rd_idx_nxt   = rd_idx_r + FW'(1);
        end else if (!inflight_r && (rd_idx_r == fill_r)) begin
          fill_nxt  = '0;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      rd_idx_r    <= '0;
      esc_pend_r  <= 1'b0;
      dropped_r   <= '0;
      inflight_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      rd_idx_r    <= rd_idx_nxt;
      esc_pend_r  <= esc_pend_nxt;
      dropped_r   <= dropped_nxt;
      inflight_r  <= inflight_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
    out_cnt_r  <= out_cnt_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_frame_byte     = out_byte_r;
  assign out_last_of_frame  = out_last_r;
  assign out_overflow_count = out_cnt_r;

  // ---------------------------------------------------------------- store
  bsfd_store #(
    .DEPTH (FRAME_BYTES)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (fill_r[AW-1:0]),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (rd_idx_r[AW-1:0]),
    .rdata (mem_rdata)
  );

  // ---------------------------------------------------------------- checks
  `BSFD_ASSERT_IMPL(a_fill_bound, 1'b1, fill_r <= FILL_MAX, "fill level beyond buffer depth")
  `BSFD_ASSERT_IMPL(a_land_free, inflight_r, !out_valid_r, "read data lands on a full output")
  `BSFD_ASSERT_IMPL(a_idx_bound, state_r == S_DRAIN, rd_idx_r <= fill_r, "drain index past fill")
  `BSFD_ASSERT_NEXT(a_esc_mark, in_acc && (in_line_byte == escape_r), esc_pend_r,
                    "escape byte did not set the mark")

endmodule

// ===== bench/byte_stuffed_frame_deframer_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for byte_stuffed_frame_deframer: line bytes in, frame beats out.
// Depends on bsfd_pkg and the deframer RTL; holds the frame predictor and the top module.

typedef struct packed {
  logic [7:0]  fbyte;
  logic        last;
  logic [15:0] drops;
} frame_beat_t;

// Tracks deframer state, predicts frame beats and checks them in order.
class frame_scoreboard;
  frame_beat_t   expected_beats[$];
  logic [7:0]    flag_val;
  logic [7:0]    esc_val;
  logic [7:0]    mask_val;
  logic [7:0]    store_mem[bsfd_pkg::FRAME_BYTES_DEF];
  int unsigned   fill;
  bit            esc_pending;
  logic [15:0]   drops;
  int unsigned   mismatches;

  function new();
    flag_val    = bsfd_pkg::FLAG_RST;
    esc_val     = bsfd_pkg::ESCAPE_RST;
    mask_val    = bsfd_pkg::MASK_RST;
    fill        = 0;
    esc_pending = 1'b0;
    drops       = '0;
    mismatches  = 0;
  endfunction

  function void set_reg(bsfd_pkg::bsfd_reg_t r, logic [7:0] v);
    case (r)
      bsfd_pkg::REG_FLAG:   flag_val = v;
      bsfd_pkg::REG_ESCAPE: esc_val  = v;
      bsfd_pkg::REG_MASK:   mask_val = v;
      default: ;
    endcase
  endfunction

  // store one unstuffed byte; a byte beyond capacity drops the frame
  function void stash(logic [7:0] b);
    if (fill < bsfd_pkg::FRAME_BYTES_DEF) begin
      store_mem[fill] = b;
      fill++;
    end else begin
      if (drops != bsfd_pkg::DROP_MAX) drops++;
      fill = 0;
    end
  endfunction

  // escape test first, so an escape equal to the flag never delimits
  function void note_line_byte(logic [7:0] b);
    frame_beat_t beat;
    int unsigned k;
    if (b == esc_val) begin
      esc_pending = 1'b1;
    end else if (b == flag_val) begin
      for (k = 0; k < fill; k++) begin
        beat.fbyte = store_mem[k];
        beat.last  = (k + 1 == fill);
        beat.drops = drops;
        expected_beats = {expected_beats, beat};
      end
      fill = 0;
    end else if (esc_pending) begin
      stash(b ^ mask_val);
      esc_pending = 1'b0;
    end else begin
      stash(b);
    end
  endfunction

  function void check_beat(logic [7:0] fb, logic last, logic [15:0] cnt);
    frame_beat_t got;
    frame_beat_t want;
    got = {fb, last, cnt};
    if (expected_beats.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected beat: byte %02h last %0b count %0d", fb, last, cnt);
    end else begin
      want = expected_beats.pop_front();
      if (want !== got) begin
        mismatches++;
        if (mismatches <= 10)
          $display("beat mismatch: expected %02h/%0b/%0d, got %02h/%0b/%0d",
                   want.fbyte, want.last, want.drops, fb, last, cnt);
      end
    end
  endfunction

  function int pending();
    return expected_beats.size();
  endfunction
endclass

module byte_stuffed_frame_deframer_tb;
  import bsfd_pkg::*;

  localparam int CYCLE_LIMIT   = 1_000_000;
  // after the last beat, allow the drain pipe and a taken byte to settle
  localparam int SETTLE_CYCLES = 8;
  localparam logic [7:0] FL = FLAG_RST;
  localparam logic [7:0] ES = ESCAPE_RST;

  // directed beats at reset settings: empty flag, extremes, stuffed flag and
  // escape, repeated escape, flag with escape pending, escape then empty flag
  localparam logic [7:0] DIRECTED [21] = '{
    FL, 8'h00, 8'hFF, ES, 8'h5E, ES, 8'h5D, FL,
    ES, ES, 8'h41, FL,
    8'h42, ES, FL, 8'h43, FL,
    ES, FL, 8'h44, FL
  };

  logic              clk          = 1'b0;
  logic              rst_n        = 1'b0;
  logic              in_valid     = 1'b0;
  logic              in_stall;
  logic [7:0]        in_line_byte = '0;
  logic              out_valid;
  logic              out_stall    = 1'b0;
  logic [7:0]        out_frame_byte;
  logic              out_last_of_frame;
  logic [15:0]       out_overflow_count;
  logic              psel         = 1'b0;
  logic              penable      = 1'b0;
  logic              pwrite       = 1'b0;
  logic [CFG_AW-1:0] paddr        = '0;
  logic [CFG_DW-1:0] pwdata       = '0;
  logic [CFG_DW-1:0] prdata;
  logic              pready;

  frame_scoreboard   sb;
  int unsigned       cycle_count = 0;
  int unsigned       items_sent  = 0;
  int                burst_left  = 0;
  logic [2:0]        run_left    = '0;

  byte_stuffed_frame_deframer DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_line_byte       (in_line_byte),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_frame_byte     (out_frame_byte),
    .out_last_of_frame  (out_last_of_frame),
    .out_overflow_count (out_overflow_count),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // watchdog: a hung handshake ends the run here
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Beat monitor. Sampled at the edge, so both sides see pre-edge values;
  // an input beat is predicted before any output beat of the same edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_line_byte(in_line_byte);
      if (out_valid && !out_stall)
        sb.check_beat(out_frame_byte, out_last_of_frame, out_overflow_count);
    end
  end

  // Receiver back-pressure, stepping through four modes on cycle_count[8:7]:
  // never stalled, coin-toss, random runs, and stalled unless cycle_count[1:0] is zero.
  always @(posedge clk) begin
    case (cycle_count[8:7])
      2'd0: out_stall <= 1'b0;
      2'd1: out_stall <= ($urandom_range(0, 1) == 1);
      2'd2: begin
        if (run_left == 0) begin
          run_left  <= 3'($urandom_range(1, 7));
          out_stall <= ~out_stall;
        end else begin
          run_left <= run_left - 3'd1;
        end
      end
      default: out_stall <= (cycle_count[1:0] != 2'd0);
    endcase
  end

  // One line beat, held until taken. The sender runs in bursts; a burst may
  // run long, and between bursts valid may drop for a random gap.
  task push_line_byte(input logic [7:0] b);
    int gap;
    in_valid     <= 1'b1;
    in_line_byte <= b;
    do @(posedge clk); while (in_stall);
    items_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                               : $urandom_range(0, 15);
    end
  endtask

  // Register write: setup then access; lands on the edge with pready high.
  task write_reg(input bsfd_reg_t r, input logic [7:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= {24'd0, v};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_reg(r, v);
  endtask

  // Hold the sender off until every predicted beat is out, then let the
  // block settle. The opening edges let the last taken beat be noted.
  task wait_idle();
    in_valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // A stuffed frame of len payload bytes and its closing flag. Payload is
  // biased towards the flag and escape values; a few plain bytes get stuffed
  // too. A broken frame gets a stray escape, a stray raw byte, or no flag.
  task send_frame(input int len, input bit broken);
    logic [7:0] b;
    int i;
    int flaw;
    for (i = 0; i < len; i++) begin
      case ($urandom_range(0, 9))
        0:       b = sb.flag_val;
        1:       b = sb.esc_val;
        default: b = 8'($urandom_range(0, 255));
      endcase
      if (b == sb.flag_val || b == sb.esc_val || $urandom_range(0, 19) == 0) begin
        push_line_byte(sb.esc_val);
        push_line_byte(b ^ sb.mask_val);
      end else begin
        push_line_byte(b);
      end
    end
    flaw = broken ? $urandom_range(0, 2) : -1;
    if (flaw == 0) push_line_byte(sb.esc_val);
    if (flaw == 1) push_line_byte(8'($urandom_range(0, 255)));
    if (flaw != 2) push_line_byte(sb.flag_val);
  endtask

  // Random frames up to a beat budget. forced_len opens the phase with one
  // frame of chosen length (buffer exactly full, or just past it).
  // Mostly short frames, some medium, a few long enough to overflow.
  task run_phase(input int budget, input int forced_len);
    int unsigned start;
    int nframes;
    int len;
    start   = items_sent;
    nframes = 0;
    if (forced_len > 0) send_frame(forced_len, 1'b0);
    while (items_sent - start < budget) begin
      case ($urandom_range(0, 11))
        0:       len = $urandom_range(60, 70);
        1, 2, 3: len = $urandom_range(9, 24);
        default: len = $urandom_range(1, 8);
      endcase
      send_frame(len, $urandom_range(0, 9) == 0);
      nframes++;
      // sender pause until the out side has fully caught up
      if (nframes % 6 == 0) wait_idle();
    end
    wait_idle();
  endtask

  initial begin
    logic [7:0] f;
    sb = new();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (DIRECTED[i]) push_line_byte(DIRECTED[i]);
    wait_idle();

    // escape equal to flag: the value only escapes, nothing is emitted;
    // restoring the escape lets the next flag flush what was stored
    write_reg(REG_ESCAPE, FL);
    push_line_byte(FL);
    push_line_byte(8'h55);
    push_line_byte(FL);
    push_line_byte(FL);
    push_line_byte(8'h31);
    wait_idle();
    write_reg(REG_ESCAPE, ES);
    push_line_byte(FL);
    wait_idle();

    // reset settings, starting with a frame that fills the buffer exactly
    run_phase(75, FRAME_BYTES_DEF);

    // low flag, high escape, all-ones mask; opens with an overflowing frame
    write_reg(REG_FLAG, 8'h00);
    write_reg(REG_ESCAPE, 8'hFF);
    write_reg(REG_MASK, 8'hFF);
    run_phase(75, 70);

    // high flag, low escape, zero mask
    write_reg(REG_FLAG, 8'hFF);
    write_reg(REG_ESCAPE, 8'h00);
    write_reg(REG_MASK, 8'h00);
    run_phase(75, FRAME_BYTES_DEF + 1);

    // random settings, flag and escape kept apart
    f = 8'($urandom_range(0, 255));
    write_reg(REG_FLAG, f);
    write_reg(REG_ESCAPE, f ^ 8'($urandom_range(1, 255)));
    write_reg(REG_MASK, 8'($urandom_range(0, 255)));
    run_phase(75, 0);

    wait_idle();
    repeat (20) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+src
src/bsfd_pkg.sv
src/bsfd_store.sv
src/byte_stuffed_frame_deframer.sv
bench/byte_stuffed_frame_deframer_tb.sv
